@@ src/lqc_pkg.sv @@
package lqc_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int REQ_WIDTH      = 3;

	typedef enum logic [REQ_WIDTH-1:0] {
		REQ_APPEND   = 3'd0,
		REQ_PUSH     = 3'd1,
		REQ_POP      = 3'd2,
		REQ_GET_CUR  = 3'd3,
		REQ_GET_LAST = 3'd4,
		REQ_NEXT     = 3'd5,
		REQ_TO_TOP   = 3'd6,
		REQ_CLEAR    = 3'd7
	} req_type_t;

endpackage

@@ src/lqc_req_if.sv @@
interface lqc_req_if
	import lqc_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [REQ_WIDTH-1:0]   req_type;
	logic [DATA_WIDTH-1:0]  data_in;

	modport source (output valid, req_type, data_in, input ready);
	modport sink   (input valid, req_type, data_in, output ready);
endinterface

@@ src/lqc_rsp_if.sv @@
interface lqc_rsp_if
	import lqc_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int CNT_WIDTH  = $clog2(DEPTH_DEF + 1)
);
	logic                   valid;
	logic                   ready;
	logic [DATA_WIDTH-1:0]  data_out;
	logic                   data_valid;
	logic                   overflow;
	logic [CNT_WIDTH-1:0]   item_count;
	logic                   is_empty;
	logic                   at_top;
	logic                   at_end;

	modport source (output valid, data_out, data_valid, overflow, item_count, is_empty,
		at_top, at_end, input ready);
	modport sink   (input valid, data_out, data_valid, overflow, item_count, is_empty,
		at_top, at_end, output ready);
endinterface

@@ src/list_queue_with_cursor_core.sv @@
// Bounded list of DEPTH words kept in a ring, with one iteration cursor. Each request beat
// (append, push front, pop front, get current, get last, next, to top, clear) returns exactly
// one result beat carrying the word read (zero when none), its valid flag, the overflow flag
// for a dropped append or push on a full list, the entry count after the request, and the
// empty / at-top / at-end flags. The block takes one request per cycle unless the output
// stalls: all pointer updates are done in the accept cycle and each request makes at most one
// access to the single-port entry memory, whose registered read data sets the latency. A result
// passes the memory read stage, then the output register, and a request is still accepted while
// a finished result waits on the output and stage 1 is empty. The cursor follows its entry
// when that entry is popped and drops to the end when the list empties or when next passes
// the last entry. The entry memory is not cleared after reset; only live entries are read.
module list_queue_with_cursor_core
	import lqc_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lqc_req_if.sink   req,
	lqc_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	// Ring addition: a is a slot, b is at most DEPTH where the result is used, so one compare-subtract wraps it.
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// List and cursor state
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         cursor_q;
	logic [CW-1:0]         total_q;
	logic                  cur_vld_q;

	logic [AW-1:0]         head_d;
	logic [AW-1:0]         cursor_d;
	logic [CW-1:0]         total_d;
	logic                  cur_vld_d;

	// Memory access for the accepted request
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;

	logic                  dvalid;
	logic                  ovf;
	logic                  empty_d;
	logic                  top_d;

	logic                  was_empty;
	logic                  full;
	logic [AW-1:0]         last_slot;
	logic [AW-1:0]         tail_slot;
	logic [AW-1:0]         prev_head;
	logic [AW-1:0]         next_head;
	logic                  accept;
	req_type_t             req_code;

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	// Stage 1: memory read stage
	logic                  v_s1;
	logic [DATA_WIDTH-1:0] rd_data_s1;
	logic                  dvalid_s1;
	logic                  ovf_s1;
	logic [CW-1:0]         cnt_s1;
	logic                  empty_s1;
	logic                  top_s1;
	logic                  end_s1;

	// Stage 2: output register
	logic                  v_s2;
	logic [DATA_WIDTH-1:0] data_s2;
	logic                  dvalid_s2;
	logic                  ovf_s2;
	logic [CW-1:0]         cnt_s2;
	logic                  empty_s2;
	logic                  top_s2;
	logic                  end_s2;

	logic                  s2_free;
	logic                  s1_adv;

	// Handshake: the output register frees stage 1, stage 1 frees the request side.
	assign s2_free   = !v_s2 || rsp.ready;
	assign s1_adv    = v_s1 && s2_free;
	assign req.ready = !v_s1 || s2_free;
	assign accept    = req.valid && req.ready;
	assign req_code  = req_type_t'(req.req_type);

	assign was_empty = (total_q == '0);
	assign full      = (total_q == CW'(DEPTH));
	assign tail_slot = ring_add(head_q, total_q);
	assign last_slot = ring_add(head_q, total_q - CW'(1));
	assign prev_head = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign next_head = ring_add(head_q, CW'(1));

	always_comb begin
		head_d    = head_q;
		cursor_d  = cursor_q;
		total_d   = total_q;
		cur_vld_d = cur_vld_q;
		wr_en     = 1'b0;
		wr_addr   = tail_slot;
		rd_en     = 1'b0;
		rd_addr   = cursor_q;
		dvalid    = 1'b0;
		ovf       = 1'b0;
		case (req_code)
			REQ_APPEND, REQ_PUSH: begin
				if (full) begin
					// drop the word, flag it
					ovf = 1'b1;
				end else begin
					if (was_empty) begin
						wr_addr = head_q;
					end else if (req_code == REQ_PUSH) begin
						wr_addr = prev_head;
						head_d  = prev_head;
					end else begin
						wr_addr = tail_slot;
					end
					wr_en   = 1'b1;
					total_d = total_q + CW'(1);
					if (was_empty) begin
						cursor_d  = wr_addr;
						cur_vld_d = 1'b1;
					end
				end
			end
			REQ_POP: begin
				if (!was_empty) begin
					rd_en   = 1'b1;
					rd_addr = head_q;
					dvalid  = 1'b1;
					head_d  = next_head;
					total_d = total_q - CW'(1);
					if (total_q == CW'(1)) begin
						cur_vld_d = 1'b0;
					end else if (cur_vld_q && cursor_q == head_q) begin
						// cursor follows its popped entry
						cursor_d = next_head;
					end
				end
			end
			REQ_GET_CUR: begin
				if (cur_vld_q) begin
					rd_en  = 1'b1;
					dvalid = 1'b1;
				end
			end
			REQ_GET_LAST: begin
				if (!was_empty) begin
					rd_en   = 1'b1;
					rd_addr = last_slot;
					dvalid  = 1'b1;
				end
			end
			REQ_NEXT: begin
				if (cur_vld_q) begin
					rd_en  = 1'b1;
					dvalid = 1'b1;
					if (cursor_q == last_slot) begin
						cur_vld_d = 1'b0;
					end else begin
						cursor_d = ring_add(cursor_q, CW'(1));
					end
				end
			end
			REQ_TO_TOP: begin
				cursor_d  = head_q;
				cur_vld_d = !was_empty;
			end
			REQ_CLEAR: begin
				head_d    = '0;
				cursor_d  = '0;
				total_d   = '0;
				cur_vld_d = 1'b0;
			end
			default: begin
				cur_vld_d = cur_vld_q;
			end
		endcase
	end

	assign empty_d = (total_d == '0);
	assign top_d   = empty_d ? !cur_vld_d : (cur_vld_d && cursor_d == head_d);

	// Pointer state advances on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			cursor_q  <= '0;
			total_q   <= '0;
			cur_vld_q <= 1'b0;
		end else if (accept) begin
			head_q    <= head_d;
			cursor_q  <= cursor_d;
			total_q   <= total_d;
			cur_vld_q <= cur_vld_d;
		end
	end

	// Entry memory: at most one write or one registered read per request.
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem_q[wr_addr] <= req.data_in;
		end
		if (accept && rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dvalid_s1 <= dvalid;
			ovf_s1    <= ovf;
			cnt_s1    <= total_d;
			empty_s1  <= empty_d;
			top_s1    <= top_d;
			end_s1    <= !cur_vld_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	// Output register: hold while the sink stalls, zero the word when nothing was read.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			data_s2   <= dvalid_s1 ? rd_data_s1 : '0;
			dvalid_s2 <= dvalid_s1;
			ovf_s2    <= ovf_s1;
			cnt_s2    <= cnt_s1;
			empty_s2  <= empty_s1;
			top_s2    <= top_s1;
			end_s2    <= end_s1;
		end
	end

	assign rsp.valid      = v_s2;
	assign rsp.data_out   = data_s2;
	assign rsp.data_valid = dvalid_s2;
	assign rsp.overflow   = ovf_s2;
	assign rsp.item_count = cnt_s2;
	assign rsp.is_empty   = empty_s2;
	assign rsp.at_top     = top_s2;
	assign rsp.at_end     = end_s2;

endmodule
